@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the header walker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/pdhw_pkg.sv @@
// Package: types, schema tables and phase codes of the header walker.
package pdhw_pkg;
   localparam logic [2:0] PH_TAG      = 3'd0;
   localparam logic [2:0] PH_TAG_BARE = 3'd1;
   localparam logic [2:0] PH_LEN      = 3'd2;
   localparam logic [2:0] PH_LONG     = 3'd3;
   localparam logic [2:0] PH_DISCARD  = 3'd4;
   localparam logic [2:0] PH_SKIP     = 3'd5;
   localparam logic [2:0] PH_WLEN     = 3'd6;
   localparam logic [2:0] PH_WDISCARD = 3'd7;

   localparam logic [4:0] LAST_STEP = 5'd29;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [31:0] position;
   } q_entry_type;

   typedef struct packed {
      logic        record_valid;
      logic [4:0]  element_id;
      logic [7:0]  element_tag;
      logic [1:0]  nest_level;
      logic [31:0] content_offset;
      logic [31:0] content_length;
      logic        done_res;
      logic        parse_ok;
   } rsp_type;

   typedef struct packed {
      logic finished;
   } status_type;

   function automatic logic [7:0] elem_tag(input logic [4:0] e);
      logic [7:0] t;
      begin
         case (e)
            5'd0: t = 8'h06;  5'd1: t = 8'h30;  5'd2: t = 8'h02;  5'd3: t = 8'h31;
            5'd4: t = 8'h30;  5'd5: t = 8'h30;  5'd6: t = 8'h30;  5'd7: t = 8'h02;
            5'd8: t = 8'h02;  5'd9: t = 8'h30;  5'd10: t = 8'h30; 5'd11: t = 8'h30;
            5'd12: t = 8'h30; 5'd13: t = 8'h30; 5'd14: t = 8'hA1; 5'd15: t = 8'hA2;
            5'd16: t = 8'hA3; 5'd17: t = 8'h30; 5'd18: t = 8'h03; 5'd19: t = 8'h30;
            5'd20: t = 8'h31; 5'd21: t = 8'h30; 5'd22: t = 8'h02; 5'd23: t = 8'h30;
            5'd24: t = 8'h30; 5'd25: t = 8'hA0; 5'd26: t = 8'h30; 5'd27: t = 8'h04;
            5'd28: t = 8'hA1;
            default: t = 8'h00;
         endcase
         return t;
      end
   endfunction

   function automatic logic [1:0] elem_level(input logic [4:0] e);
      logic [1:0] l;
      begin
         case (e)
            5'd0, 5'd1: l = 2'd0;
            5'd2, 5'd3, 5'd4, 5'd5, 5'd19, 5'd20: l = 2'd1;
            5'd6, 5'd17, 5'd18, 5'd21: l = 2'd2;
            default: l = 2'd3;
         endcase
         return l;
      end
   endfunction
endpackage

@@ rtl/pkcs7_der_header_walker.sv @@
// Top level of the PKCS#7 signedData DER header walker.
//
//  channel | ports                 | handshake
//  --------+-----------------------+------------------------------
//  request | req_data_byte         | req_valid / req_stall
//  result  | rsp_* record fields   | rsp_valid / rsp_stall
//  config  | csr_write_data        | csr_write_enable, no wait
//
// One byte per cycle sustained while the result side does not stall;
// the walker's per-byte step over the schema state is combinational, and
// each byte passes the two-entry byte queue, then the result register.
// Reset is synchronous and puts the walker at the outer sequence tag.
// A stalled result holds; the queue keeps taking bytes until it is full.
`include "assert_macros.svh"
module pkcs7_der_header_walker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_record_valid,
   output logic [4:0]  rsp_element_id,
   output logic [7:0]  rsp_element_tag,
   output logic [1:0]  rsp_nest_level,
   output logic [31:0] rsp_content_offset,
   output logic [31:0] rsp_content_length,
   output logic        rsp_done_res,
   output logic        rsp_parse_ok
);
   import pdhw_pkg::*;

   logic        q_valid, q_pop;
   q_entry_type q_entry;
   rsp_type     rsp_data;
   status_type  status;

   // front: position tagging and byte queue
   pdhw_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data_byte,
      .q_valid, .q_entry, .q_pop
   );

   // back: schema walk and result register
   pdhw_parser u_parser (
      .clock, .reset, .csr_write_enable, .csr_write_data,
      .q_valid, .q_entry, .q_pop, .rsp_valid, .rsp_stall, .rsp_data, .status
   );

   assign rsp_record_valid   = rsp_data.record_valid;
   assign rsp_element_id     = rsp_data.element_id;
   assign rsp_element_tag    = rsp_data.element_tag;
   assign rsp_nest_level     = rsp_data.nest_level;
   assign rsp_content_offset = rsp_data.content_offset;
   assign rsp_content_length = rsp_data.content_length;
   assign rsp_done_res       = rsp_data.done_res;
   assign rsp_parse_ok       = rsp_data.parse_ok;

   // a success flag only travels with done
   `ASSERT_SAME(ok_needs_done, clock, reset, rsp_valid && rsp_parse_ok, rsp_done_res)
   // a result without record carries a zero element id and content length
   `ASSERT_SAME(norec_zero, clock, reset, rsp_valid && !rsp_record_valid,
                rsp_element_id == 5'd0 && rsp_content_length == 32'd0)
   // a done result means the walker has stopped
   `ASSERT_SAME(done_stops, clock, reset, rsp_valid && rsp_done_res, status.finished)
endmodule

@@ rtl/pdhw_front.sv @@
// Front end: accepts bytes, tags each with its file position and queues it.
module pdhw_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_data_byte,
   output logic                 q_valid,
   output pdhw_pkg::q_entry_type q_entry,
   input  logic                 q_pop
);
   import pdhw_pkg::*;

   q_entry_type mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic [31:0] pos_ff, pos_in;
   logic        push;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_entry   = mem_ff[rd_ptr_ff];

   always_comb begin
      pos_in    = push ? pos_ff + 32'd1 : pos_ff;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= '{data_byte: req_data_byte, position: pos_ff};
      end
   end
endmodule

@@ rtl/pdhw_parser.sv @@
// Back end: schema walker over queued bytes, with a registered result.
module pdhw_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [31:0]           csr_write_data,
   input  logic                  q_valid,
   input  pdhw_pkg::q_entry_type q_entry,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pdhw_pkg::rsp_type     rsp_data,
   output pdhw_pkg::status_type  status
);
   import pdhw_pkg::*;

   logic [31:0] total_ff, total_in;
   logic [4:0]  step_ff, step_in;
   logic [2:0]  phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  left_ff, left_in;
   logic [31:0] skip_ff, skip_in;
   logic [7:0]  tag_ff, tag_in;
   logic        fin_ff, fin_in;
   logic        out_v_ff, out_v_in;
   rsp_type     out_ff, out_in;

   rsp_type     res;
   logic        res_v;
   logic [7:0]  b;
   logic [31:0] pos;
   logic        do_cmp;
   logic [31:0] clen;
   logic        do_adv, adv_rec, adv_done;
   logic [4:0]  adv_e;
   logic [4:0]  s, e, skip_to;
   logic [2:0]  p;
   logic        resolved, present, tfail;
   logic [6:0]  n;
   logic [31:0] acc_new, snew;
   logic [2:0]  lnew;
   logic [32:0] off;
   logic        bad;

   assign b         = q_entry.data_byte;
   assign pos       = q_entry.position;
   assign q_pop     = q_valid && (!out_v_ff || !rsp_stall);
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign status.finished = fin_ff;

   always_comb begin
      total_in = csr_write_enable ? csr_write_data : total_ff;
      step_in = step_ff; phase_in = phase_ff; acc_in = acc_ff; left_in = left_ff;
      skip_in = skip_ff; tag_in = tag_ff; fin_in = fin_ff;
      res = '0; res_v = 1'b0; do_cmp = 1'b0; clen = '0;
      do_adv = 1'b0; adv_rec = 1'b0; adv_done = 1'b0; adv_e = '0;
      s = step_ff; p = phase_ff; e = '0; skip_to = '0; resolved = 1'b0;
      present = 1'b0; tfail = 1'b0; n = '0; acc_new = '0; snew = '0; lnew = '0;
      off = '0; bad = 1'b0;
      if (q_pop && !fin_ff) begin
         case (phase_ff)
            PH_TAG, PH_TAG_BARE: begin
               // at most three optional elements are passed over in a row
               for (int i = 0; i < 5; i++) begin
                  if (!resolved) begin
                     if (s == 5'd0) begin
                        resolved = 1'b1;
                        if (b != 8'h30) tfail = 1'b1;
                        else begin tag_in = b; phase_in = PH_LEN; end
                     end else if (s > LAST_STEP) begin
                        resolved = 1'b1; tfail = 1'b1;
                     end else begin
                        e = s - 5'd1;
                        if (p == PH_TAG && (e == 5'd1 || e == 5'd5 || e == 5'd7 ||
                                            e == 5'd19)) begin
                           case (e)
                              5'd1: begin present = 1'b1; skip_to = 5'd2; end
                              5'd5: begin present = (b == 8'hA0); skip_to = 5'd19; end
                              5'd7: begin
                                 present = (b[7:6] == 2'b10) && (b[4:0] == 5'd0);
                                 skip_to = 5'd8;
                              end
                              default: begin present = (b == 8'hA1); skip_to = 5'd20; end
                           endcase
                           if (present) begin
                              phase_in = PH_WLEN; resolved = 1'b1;
                           end else begin
                              s = skip_to + 5'd1; p = PH_TAG;
                           end
                        end else if (b == elem_tag(e)) begin
                           tag_in = b; phase_in = PH_LEN; resolved = 1'b1;
                        end else if (e == 5'd14 || e == 5'd15 || e == 5'd16 ||
                                     e == 5'd25) begin
                           s = s + 5'd1; p = PH_TAG;
                        end else if (e == 5'd28) begin
                           resolved = 1'b1; fin_in = 1'b1; res_v = 1'b1;
                           res.done_res = 1'b1; res.parse_ok = 1'b1;
                        end else begin
                           resolved = 1'b1; tfail = 1'b1;
                        end
                     end
                  end
               end
               step_in = s;
               if (tfail) begin
                  fin_in = 1'b1; res_v = 1'b1; res.done_res = 1'b1;
               end
            end
            PH_LEN: begin
               if (b[7]) begin
                  n = b[6:0];
                  if (n == 7'd0) begin
                     do_cmp = 1'b1;
                  end else if (n <= 7'd4) begin
                     acc_in = '0; left_in = n[2:0]; phase_in = PH_LONG;
                  end else begin
                     skip_in = {25'd0, n}; phase_in = PH_DISCARD;
                  end
               end else begin
                  do_cmp = 1'b1; clen = {24'd0, b};
               end
            end
            PH_LONG: begin
               acc_new = {acc_ff[23:0], b};
               acc_in  = acc_new;
               lnew    = (left_ff != 3'd0) ? left_ff - 3'd1 : 3'd0;
               left_in = lnew;
               if (lnew == 3'd0) begin do_cmp = 1'b1; clen = acc_new; end
            end
            PH_DISCARD: begin
               snew = (skip_ff != 32'd0) ? skip_ff - 32'd1 : 32'd0;
               skip_in = snew;
               if (snew == 32'd0) do_cmp = 1'b1;
            end
            PH_SKIP: begin
               snew = (skip_ff != 32'd0) ? skip_ff - 32'd1 : 32'd0;
               skip_in = snew;
               if (snew == 32'd0 && step_ff >= 5'd1 && step_ff <= LAST_STEP) begin
                  do_adv = 1'b1; adv_e = step_ff - 5'd1;
               end
            end
            PH_WLEN: begin
               n = b[7] ? b[6:0] : 7'd0;
               if (n == 7'd0) phase_in = PH_TAG_BARE;
               else begin skip_in = {25'd0, n}; phase_in = PH_WDISCARD; end
            end
            default: begin
               snew = (skip_ff != 32'd0) ? skip_ff - 32'd1 : 32'd0;
               skip_in = snew;
               if (snew == 32'd0) phase_in = PH_TAG_BARE;
            end
         endcase

         // element header complete: bounds check, then stop on overrun, or enter or skip
         if (do_cmp) begin
            off = {1'b0, pos} + 33'd1;
            bad = ({1'b0, off} + {2'b0, clen}) > {2'b0, total_ff};
            if (step_ff == 5'd0) begin
               if (bad) begin
                  fin_in = 1'b1; res_v = 1'b1; res.done_res = 1'b1;
               end else begin
                  step_in = 5'd1; phase_in = PH_TAG;
               end
            end else begin
               e = step_ff - 5'd1;
               res_v = 1'b1;
               res.record_valid   = 1'b1;
               res.element_id     = e;
               res.element_tag    = tag_ff;
               res.nest_level     = elem_level(e);
               res.content_offset = off[31:0];
               res.content_length = clen;
               if (bad) begin
                  fin_in = 1'b1; res.done_res = 1'b1;
               end else if (e == 5'd1 || e == 5'd5 || e == 5'd6 || e == 5'd20 ||
                            e == 5'd21) begin
                  step_in = e + 5'd2; phase_in = PH_TAG;
               end else if (clen == 32'd0) begin
                  do_adv = 1'b1; adv_rec = 1'b1; adv_e = e;
               end else begin
                  skip_in = clen; phase_in = PH_SKIP;
               end
            end
         end

         // element content ended: finish the parse or move to the next schema step
         if (do_adv) begin
            phase_in = PH_TAG;
            if (adv_e == 5'd28) begin
               fin_in = 1'b1; adv_done = 1'b1;
            end else if (adv_e == 5'd27) begin
               if (({1'b0, pos} + 33'd1) == {1'b0, total_ff}) begin
                  fin_in = 1'b1; adv_done = 1'b1;
               end else begin
                  step_in = LAST_STEP;
               end
            end else begin
               step_in = adv_e + 5'd2;
            end
            if (adv_rec) begin
               res.done_res = adv_done; res.parse_ok = adv_done;
            end else if (adv_done) begin
               res_v = 1'b1; res.done_res = 1'b1; res.parse_ok = 1'b1;
            end
         end
      end

      out_in = out_ff;
      out_v_in = out_v_ff && rsp_stall;
      if (q_pop && res_v) begin
         out_in = res; out_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0; step_ff <= '0; phase_ff <= PH_TAG; acc_ff <= '0;
         left_ff <= '0; skip_ff <= '0; tag_ff <= '0; fin_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         total_ff <= total_in; step_ff <= step_in; phase_ff <= phase_in;
         acc_ff <= acc_in; left_ff <= left_in; skip_ff <= skip_in;
         tag_ff <= tag_in; fin_ff <= fin_in; out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end
endmodule

@@ dv/tb_top.sv @@
// Testbench for the PKCS#7 signedData header walker: streams DER files and checks each record.
`timescale 1ns / 1ps
module tb_top;
   import pdhw_pkg::*;

   // Schema element indexes with special handling.
   localparam int EL_CONTENT      = 1;
   localparam int EL_CERT         = 5;
   localparam int EL_TBS          = 6;
   localparam int EL_CERT_VERSION = 7;
   localparam int EL_ISSUER_UID   = 14;
   localparam int EL_SUBJECT_UID  = 15;
   localparam int EL_EXTENSIONS   = 16;
   localparam int EL_CRLS         = 19;
   localparam int EL_SIGNER_INFOS = 20;
   localparam int EL_SIGNER_INFO  = 21;
   localparam int EL_AUTH_ATTRS   = 25;
   localparam int EL_DIGEST       = 27;
   localparam int EL_UNAUTH_ATTRS = 28;
   localparam int NUM_ELEMS       = 29;
   localparam int DRAIN_CYCLES    = 8;

   localparam logic [7:0] TAG_SEQ      = 8'h30;
   localparam logic [7:0] TAG_SET      = 8'h31;
   localparam logic [7:0] TAG_INT      = 8'h02;
   localparam logic [7:0] TAG_OID      = 8'h06;
   localparam logic [7:0] TAG_BITS     = 8'h03;
   localparam logic [7:0] TAG_OCTETS   = 8'h04;
   localparam logic [7:0] TAG_CTX0     = 8'hA0;
   localparam logic [7:0] TAG_CTX1     = 8'hA1;
   localparam logic [7:0] TAG_CTX2     = 8'hA2;
   localparam logic [7:0] TAG_CTX3     = 8'hA3;

   // Expected tag and nesting level per schema element.
   logic [7:0] schema_tag [NUM_ELEMS] = '{
      8'h06, 8'h30, 8'h02, 8'h31, 8'h30, 8'h30, 8'h30, 8'h02, 8'h02, 8'h30,
      8'h30, 8'h30, 8'h30, 8'h30, 8'hA1, 8'hA2, 8'hA3, 8'h30, 8'h03, 8'h30,
      8'h31, 8'h30, 8'h02, 8'h30, 8'h30, 8'hA0, 8'h30, 8'h04, 8'hA1};
   logic [1:0] schema_level [NUM_ELEMS] = '{
      2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd3, 2'd3, 2'd3,
      2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd1,
      2'd1, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3};

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_seen;

   pkcs7_der_header_walker dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_record_valid   (rsp_seen.record_valid),
      .rsp_element_id     (rsp_seen.element_id),
      .rsp_element_tag    (rsp_seen.element_tag),
      .rsp_nest_level     (rsp_seen.nest_level),
      .rsp_content_offset (rsp_seen.content_offset),
      .rsp_content_length (rsp_seen.content_length),
      .rsp_done_res       (rsp_seen.done_res),
      .rsp_parse_ok       (rsp_seen.parse_ok)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Walker predictor: own copy of the schema state and the length register.
   // ---------------------------------------------------------------------
   logic [31:0] w_total_len;
   logic [31:0] w_pos;
   int          w_step;
   logic [2:0]  w_phase;
   logic [31:0] w_acc;
   int          w_len_left;
   logic [31:0] w_skip;
   logic [7:0]  w_tag;
   bit          w_done;

   rsp_type     record_q[$];   // records the walker owes us, oldest first
   int          mismatches;

   function automatic rsp_type make_record(bit rec, int e, logic [63:0] off,
                                           logic [31:0] len, bit done, bit ok);
      rsp_type r;
      r = '0;
      if (rec) begin
         r.record_valid   = 1'b1;
         r.element_id     = e[4:0];
         r.element_tag    = w_tag;
         r.nest_level     = schema_level[e % NUM_ELEMS];
         r.content_offset = off[31:0];
         r.content_length = len;
      end
      r.done_res = done;
      r.parse_ok = done && ok;
      return r;
   endfunction

   function automatic bit is_container(int e);
      return e == EL_CONTENT || e == EL_CERT || e == EL_TBS ||
             e == EL_SIGNER_INFOS || e == EL_SIGNER_INFO;
   endfunction

   // Close element e whose content ended at pos; 1 when the parse succeeds.
   function automatic bit close_element(int e, logic [31:0] pos);
      w_phase = PH_TAG;
      if (e == EL_UNAUTH_ATTRS) begin
         w_done = 1'b1;
         return 1'b1;
      end
      if (e == EL_DIGEST) begin
         if ({32'd0, pos} + 64'd1 == {32'd0, w_total_len}) begin
            w_done = 1'b1;
            return 1'b1;
         end
         w_step = int'(LAST_STEP);
         return 1'b0;
      end
      w_step = e + 2;
      return 1'b0;
   endfunction

   task automatic header_done(input logic [31:0] pos, input logic [31:0] len,
                              output bit got, output rsp_type r);
      logic [63:0] off;
      bit          bad;
      int          e;
      bit          fin;
      off = {32'd0, pos} + 64'd1;
      bad = (off + {32'd0, len}) > {32'd0, w_total_len};
      got = 1'b1;
      r   = '0;
      if (w_step == 0) begin
         if (bad) begin
            w_done = 1'b1;
            r = make_record(1'b0, 0, 0, 0, 1'b1, 1'b0);
         end else begin
            w_step  = 1;
            w_phase = PH_TAG;
            got     = 1'b0;
         end
         return;
      end
      e = (w_step - 1) % NUM_ELEMS;
      if (bad) begin
         w_done = 1'b1;
         r = make_record(1'b1, e, off, len, 1'b1, 1'b0);
      end else if (is_container(e)) begin
         w_step  = e + 2;
         w_phase = PH_TAG;
         r = make_record(1'b1, e, off, len, 1'b0, 1'b0);
      end else if (len == 0) begin
         fin = close_element(e, pos);
         r = make_record(1'b1, e, off, len, fin, 1'b1);
      end else begin
         w_skip  = len;
         w_phase = PH_SKIP;
         r = make_record(1'b1, e, off, len, 1'b0, 1'b0);
      end
   endtask

   task automatic match_tag(input logic [7:0] b, output bit got, output rsp_type r);
      int  e;
      bit  present;
      int  skip_to;
      bit  looking;
      got = 1'b0;
      r   = '0;
      looking = 1'b1;
      while (looking) begin
         looking = 1'b0;
         if (w_step == 0) begin
            if (b != TAG_SEQ) begin
               w_done = 1'b1;
               got = 1'b1;
               r = make_record(1'b0, 0, 0, 0, 1'b1, 1'b0);
            end else begin
               w_tag   = b;
               w_phase = PH_LEN;
            end
         end else if (w_step > LAST_STEP) begin
            w_done = 1'b1;
            got = 1'b1;
            r = make_record(1'b0, 0, 0, 0, 1'b1, 1'b0);
         end else begin
            e = w_step - 1;
            if (w_phase == PH_TAG && (e == EL_CONTENT || e == EL_CERT ||
                                      e == EL_CERT_VERSION || e == EL_CRLS)) begin
               // Wrapper in front of the element; absent ones pass it over.
               if (e == EL_CONTENT) begin
                  present = 1'b1;
                  skip_to = 2;
               end else if (e == EL_CERT) begin
                  present = (b == TAG_CTX0);
                  skip_to = EL_CRLS;
               end else if (e == EL_CERT_VERSION) begin
                  present = ((b & 8'hc0) == 8'h80) && ((b & 8'h1f) == 8'h00);
                  skip_to = EL_CERT_VERSION + 1;
               end else begin
                  present = (b == TAG_CTX1);
                  skip_to = EL_SIGNER_INFOS;
               end
               if (present) begin
                  w_phase = PH_WLEN;
               end else begin
                  w_step  = skip_to + 1;
                  w_phase = PH_TAG;
                  looking = 1'b1;
               end
            end else if (b == schema_tag[e]) begin
               w_tag   = b;
               w_phase = PH_LEN;
            end else if (e == EL_ISSUER_UID || e == EL_SUBJECT_UID ||
                         e == EL_EXTENSIONS || e == EL_AUTH_ATTRS) begin
               w_step  = w_step + 1;
               w_phase = PH_TAG;
               looking = 1'b1;
            end else if (e == EL_UNAUTH_ATTRS) begin
               w_done = 1'b1;
               got = 1'b1;
               r = make_record(1'b0, 0, 0, 0, 1'b1, 1'b1);
            end else begin
               w_done = 1'b1;
               got = 1'b1;
               r = make_record(1'b0, 0, 0, 0, 1'b1, 1'b0);
            end
         end
      end
   endtask

   // Advance the predictor by one accepted byte; queue any record it causes.
   task automatic walk_byte(input logic [7:0] b);
      logic [31:0] pos;
      int          n;
      bit          got;
      rsp_type     r;
      pos   = w_pos;
      w_pos = pos + 32'd1;
      got   = 1'b0;
      r     = '0;
      if (!w_done) begin
         case (w_phase)
            PH_TAG, PH_TAG_BARE: begin
               match_tag(b, got, r);
            end
            PH_LEN: begin
               if (b[7]) begin
                  n = int'(b[6:0]);
                  if (n == 0) begin
                     header_done(pos, 32'd0, got, r);
                  end else if (n <= 4) begin
                     w_acc      = '0;
                     w_len_left = n;
                     w_phase    = PH_LONG;
                  end else begin
                     w_skip  = n;
                     w_phase = PH_DISCARD;
                  end
               end else begin
                  header_done(pos, {24'd0, b}, got, r);
               end
            end
            PH_LONG: begin
               w_acc = {w_acc[23:0], b};
               if (w_len_left > 0) w_len_left--;
               if (w_len_left == 0) header_done(pos, w_acc, got, r);
            end
            PH_DISCARD: begin
               if (w_skip > 0) w_skip--;
               if (w_skip == 0) header_done(pos, 32'd0, got, r);
            end
            PH_SKIP: begin
               if (w_skip > 0) w_skip--;
               if (w_skip == 0 && w_step >= 1 && w_step <= LAST_STEP) begin
                  if (close_element(w_step - 1, pos)) begin
                     got = 1'b1;
                     r = make_record(1'b0, 0, 0, 0, 1'b1, 1'b1);
                  end
               end
            end
            PH_WLEN: begin
               n = b[7] ? int'(b[6:0]) : 0;
               if (n == 0) begin
                  w_phase = PH_TAG_BARE;
               end else begin
                  w_skip  = n;
                  w_phase = PH_WDISCARD;
               end
            end
            default: begin
               if (w_skip > 0) w_skip--;
               if (w_skip == 0) w_phase = PH_TAG_BARE;
            end
         endcase
      end
      if (got) record_q.push_back(r);
   endtask

   // ---------------------------------------------------------------------
   // DER file builder.
   // ---------------------------------------------------------------------
   logic [7:0] der_q[$];
   int         cert_start;
   int         digest_start;

   task automatic push_random(input int n);
      repeat (n) der_q.push_back(8'($urandom));
   endtask

   // Push a length field: short, long (1..4 bytes), and for zero also the
   // indefinite-looking 0x80 and overlong forms that count as zero.
   task automatic push_len(input logic [31:0] len);
      int need;
      int n;
      if (len == 0) begin
         case ($urandom_range(0, 3))
            0: der_q.push_back(8'h00);
            1: der_q.push_back(8'h80);
            2: begin
               n = $urandom_range(5, 8);
               der_q.push_back(8'h80 | 8'(n));
               push_random(n);
            end
            default: begin
               der_q.push_back(8'h81);
               der_q.push_back(8'h00);
            end
         endcase
      end else if (len < 128 && $urandom_range(0, 1)) begin
         der_q.push_back(len[7:0]);
      end else begin
         need = (len < 256) ? 1 : (len < 65536) ? 2 : (len < 24'hffffff) ? 3 : 4;
         n = $urandom_range(need, 4);
         der_q.push_back(8'h80 | 8'(n));
         for (int i = n - 1; i >= 0; i--) der_q.push_back(8'(len >> (8 * i)));
      end
   endtask

   // Skipped element: tag, length, content.
   task automatic push_tlv(input logic [7:0] tag, input int len);
      der_q.push_back(tag);
      push_len(len);
      push_random(len);
   endtask

   task automatic push_skipped(input logic [7:0] tag);
      push_tlv(tag, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
   endtask

   // Entered element: header only, the declared length is not walked.
   task automatic push_container(input logic [7:0] tag);
      der_q.push_back(tag);
      push_len($urandom_range(0, 3000));
   endtask

   // Wrapper length: its value is dropped, only its bytes are consumed.
   task automatic push_wrapper_len();
      int n;
      case ($urandom_range(0, 2))
         0: der_q.push_back(8'($urandom_range(0, 127)));
         1: der_q.push_back(8'h80);
         default: begin
            n = $urandom_range(1, 4);
            der_q.push_back(8'h80 | 8'(n));
            push_random(n);
         end
      endcase
   endtask

   task automatic build_signed_data();
      der_q.delete();
      push_container(TAG_SEQ);
      push_skipped(TAG_OID);
      der_q.push_back(8'($urandom));      // content wrapper takes any tag
      push_wrapper_len();
      push_container(TAG_SEQ);
      push_skipped(TAG_INT);
      push_skipped(TAG_SET);
      push_skipped(TAG_SEQ);
      cert_start = der_q.size();
      if ($urandom_range(0, 3) != 0) begin
         der_q.push_back(TAG_CTX0);
         push_wrapper_len();
         push_container(TAG_SEQ);
         push_container(TAG_SEQ);
         if ($urandom_range(0, 1)) begin
            der_q.push_back($urandom_range(0, 1) ? 8'hA0 : 8'h80);
            push_wrapper_len();
            push_skipped(TAG_INT);
         end
         push_skipped(TAG_INT);
         repeat (5) push_skipped(TAG_SEQ);
         if ($urandom_range(0, 1)) push_skipped(TAG_CTX1);
         if ($urandom_range(0, 1)) push_skipped(TAG_CTX2);
         if ($urandom_range(0, 1)) push_skipped(TAG_CTX3);
         push_skipped(TAG_SEQ);
         push_skipped(TAG_BITS);
      end
      if ($urandom_range(0, 1)) begin
         der_q.push_back(TAG_CTX1);
         push_wrapper_len();
         push_skipped(TAG_SEQ);
      end
      push_container(TAG_SET);
      push_container(TAG_SEQ);
      push_skipped(TAG_INT);
      push_skipped(TAG_SEQ);
      push_skipped(TAG_SEQ);
      if ($urandom_range(0, 1)) push_skipped(TAG_CTX0);
      push_skipped(TAG_SEQ);
      digest_start = der_q.size();
      push_tlv(TAG_OCTETS, $urandom_range(400, 650));
   endtask

   // ---------------------------------------------------------------------
   // Request driver and result receiver.
   // ---------------------------------------------------------------------
   int req_burst;
   int rsp_burst;
   int rsp_wait;
   int hold_left;

   // Offer one item after a random gap; return at the edge that takes it.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      bit stalled;
      if (req_burst > 0) begin
         gap = 0;
         req_burst--;
      end else begin
         gap = $urandom_range(0, 10);
         if ($urandom_range(0, 40) == 0) req_burst = 30;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      walk_byte(b);
   endtask

   task automatic send_range(input int first, input int last);
      for (int i = first; i < last; i++) send_byte(der_q[i]);
   endtask

   // Drop valid and hold until every owed record is in, then let the
   // pipeline empty of bytes that cause nothing.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (record_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_total_length(input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      w_total_len = value;
      csr_write_enable <= 1'b0;
   endtask

   // Sample mid-cycle, where outputs are settled, and take at the next edge.
   initial begin
      bit      take;
      rsp_type got;
      rsp_type want;
      rsp_stall  = 1'b0;
      rsp_wait   = 0;
      rsp_burst  = 0;
      mismatches = 0;
      forever begin
         @(negedge clock);
         take = rsp_valid && !rsp_stall && !reset;
         got  = rsp_seen;
         if (take) begin
            if (record_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: %p", got);
            end else begin
               want = record_q.pop_front();
               if (got.record_valid   !== want.record_valid   ||
                   got.element_id     !== want.element_id     ||
                   got.element_tag    !== want.element_tag    ||
                   got.nest_level     !== want.nest_level     ||
                   got.content_offset !== want.content_offset ||
                   got.content_length !== want.content_length ||
                   got.done_res       !== want.done_res       ||
                   got.parse_ok       !== want.parse_ok) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
         @(posedge clock);
         if (take) begin
            if (rsp_burst > 0) begin
               rsp_wait = 0;
               rsp_burst--;
            end else begin
               rsp_wait = $urandom_range(0, 10);
               if ($urandom_range(0, 8) == 0) rsp_burst = 10;
            end
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         if (hold_left > 0) hold_left--;
         rsp_stall <= (hold_left > 0) || (rsp_wait > 0);
      end
   end

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------

   // Outer header through content info, widest length bound; the receiver
   // holds off meanwhile so the block backs up onto its input.
   task automatic test_header_items();
      write_total_length(32'hffff_ffff);
      hold_left = 200;
      send_range(0, cert_start);
   endtask

   // Certificate and signer fields with random content; pause once midway
   // until every owed record has come back.
   task automatic test_body_items();
      int mid;
      mid = cert_start + (digest_start - cert_start) / 2;
      send_range(cert_start, mid);
      wait_drained();
      send_range(mid, digest_start);
   endtask

   // Tighten the bound to the file end, then walk the digest and whatever
   // follows it: end of file, an unauthenticated-attributes element, or a
   // stray byte.
   task automatic test_tail_items();
      int last;
      case ($urandom_range(0, 2))
         0: ;
         1: push_tlv(TAG_CTX1, $urandom_range(0, 20));
         default: der_q.push_back(8'($urandom_range(0, 8'hA0)));
      endcase
      last = der_q.size();
      wait_drained();
      write_total_length(last);
      send_range(digest_start, last);
   endtask

   // After the parse ends the walker only counts bytes.
   task automatic test_trailing_items();
      wait_drained();
      write_total_length(32'd0);
      repeat (30) send_byte(8'($urandom));
      wait_drained();
      write_total_length($urandom);
      repeat (10) send_byte(8'($urandom));
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_burst        = 0;
      hold_left        = 0;
      w_total_len      = '0;
      w_pos            = '0;
      w_step           = 0;
      w_phase          = PH_TAG;
      w_acc            = '0;
      w_len_left       = 0;
      w_skip           = '0;
      w_tag            = '0;
      w_done           = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      build_signed_data();
      test_header_items();
      test_body_items();
      test_tail_items();
      test_trailing_items();
      wait_drained();

      if (mismatches == 0 && record_q.size() == 0) begin
         $display("[pkcs7_der_header_walker] OK");
      end else begin
         $display("[pkcs7_der_header_walker] ERROR");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #3_000_000;
      $display("[pkcs7_der_header_walker] ERROR");
      $finish;
   end
endmodule
